/* hw/rtl/mtp_pkg.sv */
// Shared constants and cell link type for the median-time-past window.
package mtp_pkg;

    // Default window depth
    localparam int unsigned WINDOW_SIZE = 11;
    // Timestamp width
    localparam int unsigned TIME_W = 32;

    // Flags passed from each cell to its right-hand neighbor
    typedef struct packed {
        logic evict_seen;  // oldest entry sits at or left of this cell
        logic le;          // compacted value here is <= incoming time
    } mtp_link_t;

endpackage

/* hw/rtl/mtp_cell.sv */
// One slot of the sorted window: holds a time and its age, updates from neighbors.
module mtp_cell
    import mtp_pkg::*;
#(
    parameter int unsigned WIN      = WINDOW_SIZE,
    parameter int unsigned AGE_W    = 4,
    parameter int unsigned CELL_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              start,
    input  logic [TIME_W-1:0] new_time,
    input  mtp_link_t         link_in,
    input  logic [TIME_W-1:0] prev_rem_time,
    input  logic [AGE_W-1:0]  prev_rem_age,
    input  logic [TIME_W-1:0] right_time,
    input  logic [AGE_W-1:0]  right_age,
    output mtp_link_t         link_out,
    output logic [TIME_W-1:0] rem_time,
    output logic [AGE_W-1:0]  rem_age,
    output logic [TIME_W-1:0] time_cur,
    output logic [AGE_W-1:0]  age_cur,
    output logic [TIME_W-1:0] time_upd
);

    localparam logic [AGE_W-1:0] OLDEST   = AGE_W'(WIN - 1);
    localparam logic [AGE_W-1:0] AGE_INIT = AGE_W'(CELL_IDX);
    localparam bit               IS_LAST  = (CELL_IDX == WIN - 1);

    logic [TIME_W-1:0] time_reg, time_next;
    logic [AGE_W-1:0]  age_reg, age_next;

    // Compacted view: entries right of the evicted one shift left by one
    always_comb
    begin
        link_out.evict_seen = link_in.evict_seen || (age_reg == OLDEST);
        rem_time = link_out.evict_seen ? right_time : time_reg;
        rem_age  = link_out.evict_seen ? right_age  : age_reg;
        link_out.le = IS_LAST ? 1'b0 : (rem_time <= new_time);
    end

    // Insert the new time at its sorted position, or on start load it into every cell
    always_comb
    begin
        priority if (start)
        begin
            time_next = new_time;
            age_next  = AGE_INIT;
        end
        else if (link_out.le)
        begin
            time_next = rem_time;
            age_next  = rem_age + AGE_W'(1);
        end
        else if (link_in.le)
        begin
            time_next = new_time;
            age_next  = '0;
        end
        else
        begin
            time_next = prev_rem_time;
            age_next  = prev_rem_age + AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            age_reg  <= AGE_INIT;
        end
        else if (load)
        begin
            time_reg <= time_next;
            age_reg  <= age_next;
        end
    end

    assign time_cur = time_reg;
    assign age_cur  = age_reg;
    assign time_upd = time_next;

endmodule

/* hw/rtl/median_time_past_window_unit.sv */
// Top level: sorted chain of window cells with a registered median output.
// Timing: median_time comes from the output register, valid the cycle after the input transfer.
// Throughput: 1 item per cycle; the cell chain inserts the newest time and evicts
//   the oldest in a single update. in_stall follows out_stall while a result waits.
// Reset: window holds zeros with ages 0..WINDOW_SIZE-1, output register empty.
module median_time_past_window_unit
    import mtp_pkg::*;
#(
    parameter int unsigned WIN = WINDOW_SIZE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [TIME_W-1:0] block_time,
    input  logic              chain_start,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TIME_W-1:0] median_time
);

    localparam int unsigned AGE_W = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int unsigned MID   = WIN / 2;

    logic                  accept;
    mtp_link_t             link   [WIN+1];
    logic [TIME_W-1:0]     rem_t  [WIN+1];
    logic [AGE_W-1:0]      rem_a  [WIN+1];
    logic [TIME_W-1:0]     cur_t  [WIN+1];
    logic [AGE_W-1:0]      cur_a  [WIN+1];
    logic [TIME_W-1:0]     upd_t  [WIN];
    logic                  out_valid_reg;
    logic [TIME_W-1:0]     median_reg;

    // Take a transfer when the output slot is free or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Chain boundaries
    assign link[0].evict_seen = 1'b0;
    assign link[0].le         = 1'b1;
    assign rem_t[0]           = '0;
    assign rem_a[0]           = '0;
    assign cur_t[WIN]         = '0;
    assign cur_a[WIN]         = '0;

    // Row of cells, ascending from index 0
    for (genvar i = 0; i < WIN; i++)
    begin : g_cell
        mtp_cell #(
            .WIN      (WIN),
            .AGE_W    (AGE_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .load          (accept),
            .start         (chain_start),
            .new_time      (block_time),
            .link_in       (link[i]),
            .prev_rem_time (rem_t[i]),
            .prev_rem_age  (rem_a[i]),
            .right_time    (cur_t[i+1]),
            .right_age     (cur_a[i+1]),
            .link_out      (link[i+1]),
            .rem_time      (rem_t[i+1]),
            .rem_age       (rem_a[i+1]),
            .time_cur      (cur_t[i]),
            .age_cur       (cur_a[i]),
            .time_upd      (upd_t[i])
        );
    end

    // Output register: median of the updated window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            median_reg <= upd_t[MID];
        end
    end

    assign out_valid   = out_valid_reg;
    assign median_time = median_reg;

endmodule

/* tb/tb_median_time_past_window_unit.sv */
// Testbench for the median-time-past window: directed table, random chains, checked medians.
`timescale 1ns / 100ps

module tb_median_time_past_window_unit;
    import mtp_pkg::*;

    // Directed stimulus row: median is typed in only where known is set
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              start;
        logic              known;
        logic [TIME_W-1:0] median;
    } plan_row_t;

    localparam int PLAN_LEN = 22;
    localparam logic [TIME_W-1:0] TOP = {TIME_W{1'b1}};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [TIME_W-1:0] block_time = '0;
    logic              chain_start = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [TIME_W-1:0] median_time;

    // Predictor copy of the window, slot 0 newest
    logic [TIME_W-1:0] window_times [WINDOW_SIZE];
    logic [TIME_W-1:0] median_due [$];
    int unsigned       mismatch_count = 0;

    // Idling controls for the feeder and the receiver process
    int unsigned feed_gap_pct = 0;
    int unsigned drain_stall_pct = 0;
    int unsigned hold_request = 0;

    // Random chain state
    logic [TIME_W-1:0] chain_now = '0;
    logic [TIME_W-1:0] last_stamp = '0;

    plan_row_t plan [PLAN_LEN] = '{
        // window still holds reset zeros
        '{32'h0000_0005, 1'b0, 1'b1, 32'h0000_0000},
        '{TOP,           1'b0, 1'b1, 32'h0000_0000},
        // chain start at the top of the range
        '{TOP,           1'b1, 1'b1, TOP},
        '{32'h0000_0000, 1'b0, 1'b1, TOP},
        '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
        // repeated chain start drops all history
        '{32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678},
        '{32'h9ABC_DEF0, 1'b1, 1'b1, 32'h9ABC_DEF0},
        // equal timestamps
        '{32'h9ABC_DEF0, 1'b0, 1'b1, 32'h9ABC_DEF0},
        '{32'h9ABC_DEF0, 1'b0, 1'b1, 32'h9ABC_DEF0},
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        // mixed values; medians taken from the predictor
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{TOP,           1'b0, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0000_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h0F0F_0F0F, 1'b0, 1'b0, 32'h0},
        '{32'hF0F0_F0F0, 1'b0, 1'b0, 32'h0},
        '{32'h3333_3333, 1'b0, 1'b0, 32'h0},
        '{32'hCCCC_CCCC, 1'b0, 1'b0, 32'h0}
    };

    median_time_past_window_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .block_time (block_time),
        .chain_start(chain_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .median_time(median_time)
    );

    // Clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Update the window with one block and return the new median
    function automatic logic [TIME_W-1:0] median_after(input logic [TIME_W-1:0] stamp,
                                                       input logic start);
        logic [TIME_W-1:0] sorted [WINDOW_SIZE];
        logic [TIME_W-1:0] v;
        int j;
        if (start)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
                window_times[i] = stamp;
        end
        else
        begin
            for (int i = WINDOW_SIZE - 1; i > 0; i--)
                window_times[i] = window_times[i - 1];
            window_times[0] = stamp;
        end
        // insertion sort, ascending
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            v = window_times[i];
            j = i;
            while (j > 0 && sorted[j - 1] > v)
            begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[WINDOW_SIZE / 2];
    endfunction

    task automatic flag_mismatch(input string what, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        if (mismatch_count < 10)
            $display("mismatch at %0t: %s expected %h actual %h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Offer one block until transferred, then record its expected median
    task automatic offer_block(input logic [TIME_W-1:0] stamp, input logic start,
                               input logic known, input logic [TIME_W-1:0] median);
        logic taken;
        logic [TIME_W-1:0] predicted;
        while (feed_gap_pct != 0 && $urandom_range(99) < feed_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        block_time  <= stamp;
        chain_start <= start;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        predicted = median_after(stamp, start);
        median_due.push_back(known ? median : predicted);
        last_stamp = stamp;
    endtask

    // Mostly well-formed chains with small forward steps, some noise
    task automatic random_blocks(input int count, input int unsigned gap,
                                 input int unsigned stall, input int hold_at);
        int unsigned roll;
        logic [TIME_W-1:0] stamp;
        logic start;
        feed_gap_pct = gap;
        drain_stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_request = 60;
            roll = $urandom_range(99);
            start = 1'b0;
            if (roll < 4)
            begin
                chain_now = $urandom;
                stamp = chain_now;
                start = 1'b1;
            end
            else if (roll < 10)
                stamp = $urandom;
            else if (roll < 20)
                stamp = last_stamp;
            else
            begin
                chain_now = chain_now + 32'($urandom_range(1200));
                stamp = chain_now + 32'($urandom_range(1800)) - 32'd900;
            end
            offer_block(stamp, start, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls plus a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < drain_stall_pct);
        end
    end

    // Result checker: a transfer is out_valid high with out_stall low
    initial
    begin
        logic [TIME_W-1:0] want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (median_due.size() == 0)
                    flag_mismatch("unexpected median_time", '0, median_time);
                else
                begin
                    want = median_due.pop_front();
                    if (median_time !== want)
                        flag_mismatch("median_time", want, median_time);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
            window_times[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, no idling
        for (int r = 0; r < PLAN_LEN; r++)
            offer_block(plan[r].stamp, plan[r].start, plan[r].known, plan[r].median);

        // random phases; long receiver hold-off in two of them
        random_blocks(362, 0, 0, 120);
        random_blocks(362, 67, 0, -1);
        random_blocks(362, 0, 67, -1);
        random_blocks(362, 18, 18, 200);

        in_valid <= 1'b0;
        while (median_due.size() != 0)
            @(posedge clk);
        drain_stall_pct = 0;
        repeat (WINDOW_SIZE + 5) @(posedge clk);

        if (mismatch_count == 0 && median_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
